/* hdl/zetc_pkg.sv */
// ----------------------------------------------------------------------------
// zetc_pkg
// Shared types and constants for the Zeeman energy / torque cell unit:
// stream widths, the microcode word layout and the sequencer interfaces.
// ----------------------------------------------------------------------------
package zetc_pkg;

  // Stream payload widths (whole bytes)
  localparam int unsigned S_TDATA_W = 200;
  localparam int unsigned M_TDATA_W = 208;

  // Program counter width (24 steps)
  localparam int unsigned STEP_W = 5;

  // mu0 * 2^40, rounded
  localparam logic [20:0] MU0_Q40 = 21'd1381687;

  // Multiplier operand A
  typedef enum logic [2:0] {
    A_SX, A_SY, A_SZ, A_MS, A_D0, A_D1, A_E0, A_E1
  } a_sel_t;

  // Multiplier operand B
  typedef enum logic [2:0] {
    B_HX, B_HY, B_HZ, B_MU0, B_K0, B_K1, B_VOL
  } b_sel_t;

  // Accumulator operation on last cycle's product
  typedef enum logic [1:0] {
    ACC_NOP, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_t;

  // Product alignment before accumulation
  typedef enum logic [1:0] {
    SH_0, SH_32, SH_64
  } acc_sh_t;

  // Store into a result register: from the accumulator, or for ST_SUM and ST_OUT from other results
  typedef enum logic [3:0] {
    ST_NONE, ST_KREG, ST_TX, ST_TY, ST_TZ, ST_DOT, ST_EMAG, ST_CE, ST_SUM, ST_OUT
  } st_op_t;

  // Program flow
  typedef enum logic [1:0] {
    J_NEXT, J_EMPTY, J_END
  } jmp_t;

  typedef struct packed {
    a_sel_t              a_sel;
    b_sel_t              b_sel;
    acc_op_t             acc_op;
    acc_sh_t             acc_sh;
    st_op_t              st_op;
    jmp_t                jmp;
    logic [STEP_W-1:0]   target;
  } ucode_t;

  // Sequencer -> datapath
  typedef struct packed {
    logic   load;   // capture input item
    logic   run;    // execute current control word
    ucode_t uc;
  } seq_ctl_t;

  // Datapath -> sequencer
  typedef struct packed {
    logic ms_zero;   // empty cell
    logic out_free;  // output register can take a result
  } dp_stat_t;

endpackage

/* hdl/zetc_seq.sv */
// ----------------------------------------------------------------------------
// zetc_seq
// Microcode sequencer: program ROM, step counter, conditional jumps and
// input handshake.
// ----------------------------------------------------------------------------
module zetc_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  zetc_pkg::dp_stat_t  stat,
  output logic                in_ready,
  output zetc_pkg::seq_ctl_t  ctl
);
  import zetc_pkg::*;

  localparam logic [STEP_W-1:0] STEP_OUT = STEP_W'(23);

  function automatic ucode_t uw(input a_sel_t a, input b_sel_t b, input acc_op_t op,
                                input acc_sh_t sh, input st_op_t st, input jmp_t j,
                                input logic [STEP_W-1:0] tgt);
    ucode_t w;
    w.a_sel  = a;
    w.b_sel  = b;
    w.acc_op = op;
    w.acc_sh = sh;
    w.st_op  = st;
    w.jmp    = j;
    w.target = tgt;
    return w;
  endfunction

  // Multiply issued in step n, accumulated in n+1, readable in n+2.
  function automatic ucode_t rom(input logic [STEP_W-1:0] a);
    ucode_t w;
    w = uw(A_SX, B_HX, ACC_NOP, SH_0, ST_NONE, J_END, '0);
    unique case (a)
      5'd0:  w = uw(A_MS, B_MU0, ACC_NOP,  SH_0,  ST_NONE, J_EMPTY, STEP_OUT);
      5'd1:  w = uw(A_SY, B_HZ,  ACC_LOAD, SH_0,  ST_NONE, J_NEXT, '0);
      5'd2:  w = uw(A_SZ, B_HY,  ACC_LOAD, SH_0,  ST_KREG, J_NEXT, '0);
      5'd3:  w = uw(A_SZ, B_HX,  ACC_SUB,  SH_0,  ST_NONE, J_NEXT, '0);
      5'd4:  w = uw(A_SX, B_HZ,  ACC_LOAD, SH_0,  ST_TX,   J_NEXT, '0);
      5'd5:  w = uw(A_SX, B_HY,  ACC_SUB,  SH_0,  ST_NONE, J_NEXT, '0);
      5'd6:  w = uw(A_SY, B_HX,  ACC_LOAD, SH_0,  ST_TY,   J_NEXT, '0);
      5'd7:  w = uw(A_SX, B_HX,  ACC_SUB,  SH_0,  ST_NONE, J_NEXT, '0);
      5'd8:  w = uw(A_SY, B_HY,  ACC_LOAD, SH_0,  ST_TZ,   J_NEXT, '0);
      5'd9:  w = uw(A_SZ, B_HZ,  ACC_ADD,  SH_0,  ST_NONE, J_NEXT, '0);
      5'd10: w = uw(A_SX, B_HX,  ACC_ADD,  SH_0,  ST_NONE, J_NEXT, '0);
      5'd11: w = uw(A_SX, B_HX,  ACC_NOP,  SH_0,  ST_DOT,  J_NEXT, '0);
      5'd12: w = uw(A_D0, B_K0,  ACC_NOP,  SH_0,  ST_NONE, J_NEXT, '0);
      5'd13: w = uw(A_D0, B_K1,  ACC_LOAD, SH_0,  ST_NONE, J_NEXT, '0);
      5'd14: w = uw(A_D1, B_K0,  ACC_ADD,  SH_32, ST_NONE, J_NEXT, '0);
      5'd15: w = uw(A_D1, B_K1,  ACC_ADD,  SH_32, ST_NONE, J_NEXT, '0);
      5'd16: w = uw(A_SX, B_HX,  ACC_ADD,  SH_64, ST_NONE, J_NEXT, '0);
      5'd17: w = uw(A_SX, B_HX,  ACC_NOP,  SH_0,  ST_EMAG, J_NEXT, '0);
      5'd18: w = uw(A_E0, B_VOL, ACC_NOP,  SH_0,  ST_NONE, J_NEXT, '0);
      5'd19: w = uw(A_E1, B_VOL, ACC_LOAD, SH_0,  ST_NONE, J_NEXT, '0);
      5'd20: w = uw(A_SX, B_HX,  ACC_ADD,  SH_32, ST_NONE, J_NEXT, '0);
      5'd21: w = uw(A_SX, B_HX,  ACC_NOP,  SH_0,  ST_CE,   J_NEXT, '0);
      5'd22: w = uw(A_SX, B_HX,  ACC_NOP,  SH_0,  ST_SUM,  J_NEXT, '0);
      5'd23: w = uw(A_SX, B_HX,  ACC_NOP,  SH_0,  ST_OUT,  J_END,  '0);
      default: w = uw(A_SX, B_HX, ACC_NOP, SH_0,  ST_NONE, J_END,  '0);
    endcase
    return w;
  endfunction

  logic              busy;
  logic [STEP_W-1:0] step;
  ucode_t            uc;

  assign uc       = rom(step);
  // no item is taken while in reset
  assign in_ready = !busy && !rst;
  assign ctl.load = in_valid && in_ready;
  // result step waits for room in the output register
  assign ctl.run  = busy && ((uc.st_op != ST_OUT) || stat.out_free);
  assign ctl.uc   = uc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (ctl.load) begin
      busy <= 1'b1;
      step <= '0;
    end else if (ctl.run) begin
      unique case (uc.jmp)
        J_EMPTY: step <= stat.ms_zero ? uc.target : step + 1'b1;
        J_END: begin
          busy <= 1'b0;
          step <= '0;
        end
        default: step <= step + 1'b1;
      endcase
    end
  end

endmodule

/* hdl/zetc_dp.sv */
// ----------------------------------------------------------------------------
// zetc_dp
// Datapath: input item registers, one shared 33x33 signed multiplier,
// 96-bit accumulator, result registers, run sum and output register.
// ----------------------------------------------------------------------------
module zetc_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  zetc_pkg::seq_ctl_t             ctl,
  input  logic [zetc_pkg::S_TDATA_W-1:0] in_data,
  input  logic                           in_last,
  output zetc_pkg::dp_stat_t             stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [zetc_pkg::M_TDATA_W-1:0] out_data,
  output logic                           out_last
);
  import zetc_pkg::*;

  localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;

  // v scaled by 2^-15, rounded half away from zero, saturated to int32
  function automatic logic [31:0] trq_round(input logic [49:0] v);
    logic [49:0] vm;
    logic [35:0] u;
    vm = v[49] ? (50'd0 - v) : v;
    u  = 36'((vm + 50'd16384) >> 15);
    if (v[49]) trq_round = (u > 36'h0_8000_0000) ? 32'h8000_0000 : 32'(36'd0 - u);
    else       trq_round = (u > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : u[31:0];
  endfunction

  // captured item
  logic [15:0] spin_x, spin_y, spin_z;
  logic [31:0] field_x, field_y, field_z;
  logic [23:0] sat_magnetization;
  logic [31:0] cell_volume;
  logic        last_cell;

  // arithmetic
  logic signed [32:0] opa, opb;
  logic signed [65:0] prod;
  logic signed [95:0] pext, pshift, acc, acc_next;

  // intermediate results
  logic [44:0] kmu;          // Ms * mu0
  logic [48:0] dmag;         // |m.H| * 2^15
  logic        dpos;         // m.H > 0 -> negative energy
  logic [39:0] emag;         // |energy density|
  logic [31:0] torque_x, torque_y, torque_z;
  logic [63:0] cell_energy;
  logic [63:0] run_sum;

  logic [49:0] dval;
  logic [95:0] erund;
  logic        eneg, hi_nz;
  logic [63:0] ce_val, sum_add, sum_next;
  logic        sum_ovf;
  logic [47:0] energy_density;

  assign stat.ms_zero  = (sat_magnetization == '0);
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      spin_x            <= in_data[15:0];
      spin_y            <= in_data[31:16];
      spin_z            <= in_data[47:32];
      field_x           <= in_data[79:48];
      field_y           <= in_data[111:80];
      field_z           <= in_data[143:112];
      sat_magnetization <= in_data[167:144];
      cell_volume       <= in_data[199:168];
      last_cell         <= in_last;
    end
  end

  always_comb begin
    unique case (ctl.uc.a_sel)
      A_SX:    opa = {{17{spin_x[15]}}, spin_x};
      A_SY:    opa = {{17{spin_y[15]}}, spin_y};
      A_SZ:    opa = {{17{spin_z[15]}}, spin_z};
      A_MS:    opa = {9'd0, sat_magnetization};
      A_D0:    opa = {1'b0, dmag[31:0]};
      A_D1:    opa = {16'd0, dmag[48:32]};
      A_E0:    opa = {1'b0, emag[31:0]};
      A_E1:    opa = {25'd0, emag[39:32]};
      default: opa = '0;
    endcase
    unique case (ctl.uc.b_sel)
      B_HX:    opb = {field_x[31], field_x};
      B_HY:    opb = {field_y[31], field_y};
      B_HZ:    opb = {field_z[31], field_z};
      B_MU0:   opb = {12'd0, MU0_Q40};
      B_K0:    opb = {1'b0, kmu[31:0]};
      B_K1:    opb = {20'd0, kmu[44:32]};
      B_VOL:   opb = {1'b0, cell_volume};
      default: opb = '0;
    endcase
  end

  assign pext = {{30{prod[65]}}, prod};

  always_comb begin
    unique case (ctl.uc.acc_sh)
      SH_32:   pshift = pext <<< 32;
      SH_64:   pshift = pext <<< 64;
      default: pshift = pext;
    endcase
    unique case (ctl.uc.acc_op)
      ACC_LOAD: acc_next = pshift;
      ACC_ADD:  acc_next = acc + pshift;
      ACC_SUB:  acc_next = acc - pshift;
      default:  acc_next = acc;
    endcase
  end

  // store-side helpers; dval, erund, hi_nz and ce_val read the settled accumulator
  assign dval    = acc[49:0];
  assign erund   = acc + (96'd1 << 54);
  assign eneg    = dpos && (emag != '0);
  assign hi_nz   = |acc[95:63];
  assign ce_val  = eneg ? (hi_nz ? I64_MIN : 64'd0 - acc[63:0])
                        : (hi_nz ? I64_MAX : acc[63:0]);
  assign sum_add = run_sum + cell_energy;
  assign sum_ovf = (run_sum[63] == cell_energy[63]) && (sum_add[63] != run_sum[63]);
  assign sum_next = sum_ovf ? (cell_energy[63] ? I64_MIN : I64_MAX) : sum_add;
  assign energy_density = dpos ? 48'd0 - {8'd0, emag} : {8'd0, emag};

  always_ff @(posedge clk) begin
    if (ctl.run) begin
      prod <= opa * opb;
      acc  <= acc_next;
      unique case (ctl.uc.st_op)
        ST_KREG: kmu <= acc[44:0];
        ST_TX:   torque_x <= trq_round(acc[49:0]);
        ST_TY:   torque_y <= trq_round(acc[49:0]);
        ST_TZ:   torque_z <= trq_round(acc[49:0]);
        ST_DOT: begin
          dmag <= 49'(dval[49] ? 50'd0 - dval : dval);
          dpos <= !dval[49] && (dval != '0);
        end
        ST_EMAG: emag <= erund[94:55];
        ST_CE:   cell_energy <= ce_val;
        default: ;
      endcase
    end
  end

  // run sum and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum   <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result may replace one taken at the same edge
      out_valid <= (out_valid && !out_ready) || (ctl.run && ctl.uc.st_op == ST_OUT);
      if (ctl.run && ctl.uc.st_op == ST_SUM) begin
        run_sum <= sum_next;
      end else if (ctl.run && ctl.uc.st_op == ST_OUT && last_cell) begin
        run_sum <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.run && ctl.uc.st_op == ST_OUT) begin
      out_last <= last_cell;
      out_data <= {last_cell ? run_sum : 64'd0,
                   stat.ms_zero ? 32'd0 : torque_z,
                   stat.ms_zero ? 32'd0 : torque_y,
                   stat.ms_zero ? 32'd0 : torque_x,
                   stat.ms_zero ? 48'd0 : energy_density};
    end
  end

endmodule

/* hdl/zeeman_energy_torque_cell_unit.sv */
// ----------------------------------------------------------------------------
// zeeman_energy_torque_cell_unit
// Per-cell Zeeman energy density -mu0*Ms*(m.H), torque m x H, and the
// energy*volume sum over a run of cells, computed by a microcoded datapath.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata fields, lowest bit first                 | tlast
//  ---------+-----+-------------------------------------------------+------------
//  s_axis   | in  | spin_x 16, spin_y 16, spin_z 16, field_x 32,    | last_cell
//           |     | field_y 32, field_z 32, sat_magnetization 24,   |
//           |     | cell_volume 32                                  |
//  m_axis   | out | energy_density 48, torque_x 32, torque_y 32,    | last_result
//           |     | torque_z 32, run_energy 64                      |
//
//  Steps: 24 program steps per cell; an empty cell (Ms = 0) jumps straight
//    to the result step. A new cell is taken only once the last one is done.
//  The step count is set by the single shared 33x33 multiplier: 16 products per
//    cell (torque, dot product, Ms*mu0, energy scaling, energy*volume).
//  s_axis_tready is high while the sequencer is idle; a result waiting in the
//    output register does not block the next item until its result step.
//  Output stall: the program holds at the result step until m_axis frees up.
//  Reset (rst, synchronous): sequencer idle, run sum zero, no result pending.
//
module zeeman_energy_torque_cell_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // spin_x, spin_y, spin_z, field_x, field_y, field_z, sat_magnetization,
  // cell_volume
  input  logic [zetc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tlast,   // last_cell
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // energy_density, torque_x, torque_y, torque_z, run_energy
  output logic [zetc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast    // last_result
);
  import zetc_pkg::*;

  seq_ctl_t ctl;
  dp_stat_t stat;

  // program ROM + step counter
  zetc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .ctl      (ctl)
  );

  // shared multiplier, accumulator, result and output registers
  zetc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

/* hdl/zetc_checker.sv */
// ----------------------------------------------------------------------------
// zetc_checker
// Port-level checks for the cell unit, bound to the top level.
// ----------------------------------------------------------------------------
module zetc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [zetc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);
  import zetc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // run sum only on the closing item
  a_run_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[M_TDATA_W-1:M_TDATA_W-64] == 64'd0)
    else $error("run_energy nonzero on non-last item");

  // one cell in flight: busy right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

  // a new result is produced only from a cell in flight
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without an item in flight");

  // nothing pending after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind zeeman_energy_torque_cell_unit zetc_checker u_zetc_checker (.*);

/* dv/cell_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cell_result_checker
// Watches both streams of the Zeeman cell unit. It predicts energy density,
// torque and run energy for every accepted cell and compares each accepted
// result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module cell_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [zetc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tlast,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [zetc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                           m_axis_tlast,
  output int                             fail_count,
  output int                             pending_count,
  output int                             checked_count
);

  // mu0 * 2^40, rounded
  localparam longint unsigned MU0_SCALED = 64'd1381687;
  localparam longint E_POS_MAX = (longint'(1) <<< 47) - 1;
  localparam longint E_NEG_MIN = -(longint'(1) <<< 47);
  localparam longint SUM_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN   = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic signed [15:0] spin_x, spin_y, spin_z;
    logic signed [31:0] field_x, field_y, field_z;
    logic        [23:0] sat_mag;
    logic        [31:0] volume;
    logic               last;
  } cell_in_t;

  typedef struct {
    logic [47:0] energy;
    logic [31:0] torque_x, torque_y, torque_z;
    logic [63:0] run_energy;
    logic        last;
  } cell_out_t;

  cell_out_t pending_results[$];
  longint    run_total;
  int        err_count = 0;
  int        n_checked = 0;

  // (a - b) / 2^15, rounded half away from zero, clamped to int32
  function automatic logic [31:0] torque_term(longint a, longint b);
    longint          t;
    longint unsigned u;
    t = a - b;
    u = (t < 0) ? -t : t;
    u = (u + 64'd16384) >> 15;
    if (t < 0) begin
      if (u > 64'h8000_0000) return 32'h8000_0000;
      return -u[31:0];
    end
    if (u > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return u[31:0];
  endfunction

  // Result of one cell; updates the run total
  function automatic cell_out_t predict_cell(cell_in_t c);
    cell_out_t         r;
    longint            dot, e, ce;
    logic [63:0]       dot_abs, emag, eabs;
    logic [127:0]      scaled, cell_prod;
    logic signed [64:0] wide_sum;
    r.energy   = '0;
    r.torque_x = '0;
    r.torque_y = '0;
    r.torque_z = '0;
    if (c.sat_mag != 0) begin
      r.torque_x = torque_term(longint'(c.spin_y) * c.field_z, longint'(c.spin_z) * c.field_y);
      r.torque_y = torque_term(longint'(c.spin_z) * c.field_x, longint'(c.spin_x) * c.field_z);
      r.torque_z = torque_term(longint'(c.spin_x) * c.field_y, longint'(c.spin_y) * c.field_x);

      dot = longint'(c.spin_x) * c.field_x + longint'(c.spin_y) * c.field_y
          + longint'(c.spin_z) * c.field_z;
      dot_abs = (dot < 0) ? -dot : dot;
      scaled  = dot_abs * c.sat_mag * MU0_SCALED + (128'd1 << 54);
      emag    = scaled[118:55];
      // energy carries the opposite sign of m.H
      if (dot > 0) e = (emag > 64'h0000_8000_0000_0000) ? E_NEG_MIN : -longint'(emag);
      else e = (emag > 64'h0000_7FFF_FFFF_FFFF) ? E_POS_MAX : longint'(emag);
      r.energy = e[47:0];

      eabs      = (e < 0) ? -e : e;
      cell_prod = eabs * c.volume;
      if (e < 0) ce = (cell_prod >= (128'd1 << 63)) ? SUM_MIN : -longint'(cell_prod[63:0]);
      else ce = (cell_prod > 128'h7FFF_FFFF_FFFF_FFFF) ? SUM_MAX : longint'(cell_prod[63:0]);

      wide_sum = 65'(run_total) + 65'(ce);
      if (wide_sum > SUM_MAX) run_total = SUM_MAX;
      else if (wide_sum < SUM_MIN) run_total = SUM_MIN;
      else run_total = wide_sum[63:0];
    end
    r.last       = c.last;
    r.run_energy = '0;
    if (c.last) begin
      r.run_energy = run_total;
      run_total    = 0;
    end
    return r;
  endfunction

  task automatic check_field(string label, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    cell_in_t  cin;
    cell_out_t want;
    if (rst) begin
      pending_results.delete();
      run_total = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          err_count++;
          $display("%0t: result with nothing expected, expected none, actual %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = pending_results.pop_front();
          check_field("energy_density", want.energy,     m_axis_tdata[47:0]);
          check_field("torque_x",       want.torque_x,   m_axis_tdata[79:48]);
          check_field("torque_y",       want.torque_y,   m_axis_tdata[111:80]);
          check_field("torque_z",       want.torque_z,   m_axis_tdata[143:112]);
          check_field("run_energy",     want.run_energy, m_axis_tdata[207:144]);
          check_field("last_result",    want.last,       m_axis_tlast);
          n_checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cin.spin_x  = s_axis_tdata[15:0];
        cin.spin_y  = s_axis_tdata[31:16];
        cin.spin_z  = s_axis_tdata[47:32];
        cin.field_x = s_axis_tdata[79:48];
        cin.field_y = s_axis_tdata[111:80];
        cin.field_z = s_axis_tdata[143:112];
        cin.sat_mag = s_axis_tdata[167:144];
        cin.volume  = s_axis_tdata[199:168];
        cin.last    = s_axis_tlast;
        pending_results.insert(pending_results.size(), predict_cell(cin));
      end
    end
    fail_count    <= err_count;
    pending_count <= pending_results.size();
    checked_count <= n_checked;
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the Zeeman cell unit: a directed set of extreme cells, then
// random runs of cells with random sender gaps and receiver stalls, one long
// receiver hold-off and one sender pause. Checking lives in the checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CELL_TARGET = 1200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [zetc_pkg::S_TDATA_W-1:0] s_axis_tdata;
  logic                           s_axis_tlast;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [zetc_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tlast;

  int fail_count, pending_count, checked_count;
  int cells_sent = 0;
  int runs_closed = 0;
  int empty_cells = 0;
  int results_taken = 0;
  int cycle_count = 0;
  bit sender_burst = 0;

  zeeman_energy_torque_cell_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  cell_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wide dynamic range: full random words down to a few bits, either sign
  function automatic logic [31:0] rand_field();
    logic [31:0] v;
    v = $urandom >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [15:0] rand_spin();
    logic [15:0] v;
    v = 16'($urandom) >> $urandom_range(0, 15);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // One cell on s_axis; gap drawn first, returns at the accepting edge with
  // tvalid still high so a back-to-back cell needs no extra edge
  task automatic send_cell(input logic [15:0] sx, sy, sz, input logic [31:0] hx, hy, hz,
                           input logic [23:0] ms, input logic [31:0] vol, input logic last);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {vol, ms, hz, hy, hx, sz, sy, sx};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    cells_sent++;
    if (last) runs_closed++;
    if (ms == 0) empty_cells++;
  endtask

  task automatic send_random_cell(input logic last);
    logic [23:0] ms;
    ms = ($urandom_range(0, 9) == 0) ? 24'd0 : 24'($urandom) >> $urandom_range(0, 23);
    send_cell(rand_spin(), rand_spin(), rand_spin(), rand_field(), rand_field(), rand_field(),
              ms, $urandom >> $urandom_range(0, 31), last);
  endtask

  // Stop offering and wait until the checker holds no more predictions
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Receiver: random stall per result, bursts without stalls, one long hold-off
  initial begin
    int stall;
    bit held_off;
    bit rx_burst;
    held_off = 0;
    rx_burst = 0;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 30) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 4);
      if (!held_off && results_taken >= 150) begin
        // sender keeps offering, so the unit backs up and drops s_axis_tready
        held_off = 1;
        stall    = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      results_taken++;
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int  run_len;
    bit  paused;
    paused = 0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero field, full-scale both signs with sum clamping, empty
    // cell, torque rounding at the half point, torque clamping, m.H of zero,
    // zero volume and single-cell runs
    send_cell(16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 24'd1, 32'd1, 1'b0);
    send_cell(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_cell(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_cell(16'h8000, 16'h8000, 16'h8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_cell(16'h8000, 16'h8000, 16'h8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_cell(16'h7FFF, 16'h1234, 16'h8000, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
              24'd0, 32'hFFFF_FFFF, 1'b1);
    send_cell(16'h0000, 16'h0001, 16'h0000, 32'd0, 32'd0, 32'd16384, 24'd1000, 32'd10, 1'b0);
    send_cell(16'h0000, 16'h0000, 16'h0001, 32'd0, 32'd16384, 32'd0, 24'd1000, 32'd10, 1'b0);
    send_cell(16'h0000, 16'h0001, 16'h0000, 32'd0, 32'd0, 32'd16383, 24'd1000, 32'd10, 1'b0);
    send_cell(16'h0000, 16'h8000, 16'h7FFF, 32'd0, 32'h8000_0000, 32'h8000_0000,
              24'd500000, 32'd1000, 1'b0);
    send_cell(16'h0000, 16'h8000, 16'h8000, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF,
              24'd500000, 32'd1000, 1'b0);
    send_cell(16'h0001, 16'hFFFF, 16'h0000, 32'd5, 32'd5, 32'd0, 24'hFF_FFFF, 32'd1000, 1'b0);
    send_cell(16'h7FFF, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'd0, 32'd0,
              24'hFF_FFFF, 32'd0, 1'b1);
    send_cell(16'h5A82, 16'h5A82, 16'h0000, 32'd800000, -32'sd400000, 32'd1000,
              24'd800000, 32'd125, 1'b1);
    send_cell(16'h0000, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1,
              24'd1, 32'hFFFF_FFFF, 1'b1);

    // Random runs of cells, each closed by a last cell
    while (cells_sent < CELL_TARGET) begin
      run_len      = $urandom_range(1, 12);
      sender_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < run_len; i++) send_random_cell(i == run_len - 1);
      if (!paused && cells_sent >= CELL_TARGET / 2) begin
        paused = 1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    $display("Ran %0d cells in %0d runs (%0d empty); %0d results checked",
             cells_sent, runs_closed, empty_cells, checked_count);
    $display("Receiver held off %0d cycles once; sender paused once until drained",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
